FILE: hw/rtl/twp_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths, status and register codes of the timing-wheel pacer.
// Depends on nothing; every other file of the block but twp_fifo imports it.
package twp_pkg;

   localparam int TIME_W     = 64;
   localparam int GRAN_W     = 32;
   localparam int HOR_W      = 40;
   localparam int LIMIT_W    = 13;
   localparam int OCC_W      = 13;
   localparam int HANDLE_W   = 12;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   // Number of descriptor indices, the depth of the link store.
   localparam int HANDLE_SPACE = 1 << HANDLE_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GRANULARITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT = 2'd2;

   // Register values after reset.
   localparam logic [GRAN_W-1:0]  GRAN_RESET  = 32'd1000;
   localparam logic [HOR_W-1:0]   HOR_RESET   = 40'd1023000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PACKET   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_DUE  = 3'd4;

   // Action codes of a request.
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef struct packed {
      logic                action;
      logic [TIME_W-1:0]   now_time;
      logic [TIME_W-1:0]   send_time;
      logic [HANDLE_W-1:0] packet_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] out_handle;
      logic [TIME_W-1:0]   retry_time;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // Effective settings derived from the configuration registers.
   typedef struct packed {
      logic [GRAN_W-1:0]  gran;
      logic [HOR_W-1:0]   horizon;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   // Saturating 64-bit add.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/twp_fifo.sv
`timescale 1ns / 1ps
// Small register queue used between the front and back parts and on the result side.
// Depends on nothing but its parameters.
module twp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: hw/rtl/twp_divmod.sv
`timescale 1ns / 1ps
// Bit-serial divider that yields the wheel bucket (time / granularity) mod NUM_BUCKETS.
// Depends on twp_pkg for the time and granularity widths.
module twp_divmod import twp_pkg::*; #(
   parameter int NUM_BUCKETS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [TIME_W-1:0]              dividend,
   input  logic [GRAN_W-1:0]              divisor,
   output logic                           done,
   output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);

   localparam int BW     = $clog2(NUM_BUCKETS);
   localparam int STEP_W = $clog2(TIME_W + 1);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [GRAN_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [BW-1:0]     qmod_ff, qmod_in;
   logic [GRAN_W:0]   trial, diff;
   logic              ge;
   logic [BW:0]       qm2;

   // One quotient bit per cycle; the quotient is kept reduced modulo the wheel size.
   assign trial = {rem_ff, dvd_ff[TIME_W-1]};
   assign ge    = (trial >= {1'b0, dsr_ff});
   assign diff  = trial - {1'b0, dsr_ff};
   assign qm2   = {qmod_ff, ge};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      qmod_in  = qmod_ff;
      if (start) begin
         busy_in  = 1'b1;
         steps_in = STEP_W'(TIME_W);
         dvd_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         qmod_in  = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[TIME_W-2:0], 1'b0};
         rem_in   = ge ? diff[GRAN_W-1:0] : trial[GRAN_W-1:0];
         qmod_in  = (qm2 >= (BW+1)'(NUM_BUCKETS)) ? BW'(qm2 - (BW+1)'(NUM_BUCKETS))
                                                  : qm2[BW-1:0];
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      qmod_ff  <= qmod_in;
   end

   assign done   = done_ff;
   assign bucket = qmod_ff;

endmodule

FILE: hw/rtl/twp_front.sv
`timescale 1ns / 1ps
// Front part: configuration registers, derived settings and the request input stage.
// Depends on twp_pkg for the request and settings types.
module twp_front import twp_pkg::*; #(
   parameter int NUM_BUCKETS = 1024,
   parameter int CAPACITY    = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   input  logic                  clearing,
   output logic                  cmd_push,
   output req_type               cmd_data,
   input  logic                  cmd_full,
   output cfg_type               cfg
);

   localparam int BW     = $clog2(NUM_BUCKETS);
   localparam int SPAN_W = GRAN_W + BW;
   localparam int CMP_W  = (SPAN_W > HOR_W) ? SPAN_W : HOR_W;
   localparam logic [BW-1:0] SPAN_MUL = BW'(NUM_BUCKETS - 1);

   logic [GRAN_W-1:0]  gran_ff, gran_in;
   logic [HOR_W-1:0]   hor_ff, hor_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [GRAN_W-1:0]  gran_eff;
   logic [SPAN_W-1:0]  span_ff;
   cfg_type            cfg_ff, cfg_in;
   logic               stage_valid_ff, stage_valid_in;
   req_type            stage_ff;
   logic               accept;

   // Register writes; an index past the list is ignored.
   always_comb begin
      gran_in  = gran_ff;
      hor_in   = hor_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRANULARITY: gran_in  = csr_wdata[GRAN_W-1:0];
            CSR_HORIZON:     hor_in   = csr_wdata[HOR_W-1:0];
            CSR_QUEUE_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default:         gran_in  = gran_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gran_ff  <= GRAN_RESET;
         hor_ff   <= HOR_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         gran_ff  <= gran_in;
         hor_ff   <= hor_in;
         limit_ff <= limit_in;
      end
   end

   // A zero granularity counts as one nanosecond.
   assign gran_eff = (gran_ff == '0) ? GRAN_W'(1) : gran_ff;

   // The horizon saturates at the wheel span; the limit saturates at the capacity.
   always_comb begin
      cfg_in.gran    = gran_eff;
      cfg_in.horizon = (CMP_W'(hor_ff) < CMP_W'(span_ff)) ? hor_ff : HOR_W'(span_ff);
      cfg_in.limit   = (32'(limit_ff) > 32'(CAPACITY)) ? LIMIT_W'(CAPACITY) : limit_ff;
   end

   always_ff @(posedge clock) begin
      span_ff <= SPAN_W'(gran_eff * SPAN_MUL);
      cfg_ff  <= cfg_in;
   end

   assign cfg = cfg_ff;

   // Input stage: one request held until the command queue takes it.
   assign full     = clearing || (stage_valid_ff && cmd_full);
   assign accept   = push && !full;
   assign cmd_push = stage_valid_ff && !cmd_full;
   assign cmd_data = stage_ff;
   assign stage_valid_in = accept || (stage_valid_ff && cmd_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= req_data;
      end
   end

endmodule

FILE: hw/rtl/twp_engine.sv
`timescale 1ns / 1ps
// Back part: wheel memories, head walk and the enqueue and dequeue sequences.
// Depends on twp_pkg and on twp_divmod for the bucket index.
module twp_engine import twp_pkg::*; #(
   parameter int NUM_BUCKETS = 1024,
   parameter int CAPACITY    = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  req_type cmd_data,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data,
   output logic    clearing
);

   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SW    = $clog2(NUM_BUCKETS + 1);
   localparam int EW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [TIME_W-1:0] SPAN_RST = TIME_W'(NUM_BUCKETS - 1) * TIME_W'(GRAN_RESET);
   localparam logic [TIME_W-1:0] MAX_RST  = (TIME_W'(HOR_RESET) < SPAN_RST) ?
                                            TIME_W'(HOR_RESET) : SPAN_RST;

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_ENQ_ANCHOR = 4'd2;
   localparam logic [3:0] S_ENQ_CHECK  = 4'd3;
   localparam logic [3:0] S_ENQ_CLAMP  = 4'd4;
   localparam logic [3:0] S_ENQ_DIV    = 4'd5;
   localparam logic [3:0] S_ENQ_READ   = 4'd6;
   localparam logic [3:0] S_ENQ_WRITE  = 4'd7;
   localparam logic [3:0] S_ENQ_LINK   = 4'd8;
   localparam logic [3:0] S_DEQ_START  = 4'd9;
   localparam logic [3:0] S_DEQ_DIV    = 4'd10;
   localparam logic [3:0] S_DEQ_READ   = 4'd11;
   localparam logic [3:0] S_DEQ_CHECK  = 4'd12;
   localparam logic [3:0] S_DEQ_HEAD   = 4'd13;

   logic [3:0]          state_ff, state_in;
   req_type             item_ff, item_in;
   logic [TIME_W-1:0]   head_ff, head_in, max_ff, max_in, t_ff, t_in;
   logic [CNT_W-1:0]    elem_ff, elem_in;
   logic [BW-1:0]       b_ff, b_in, clr_ff, clr_in;
   logic [SW-1:0]       steps_ff, steps_in;
   logic                res_valid_ff, res_valid_in;
   rsp_type             res_ff, res_in;

   // Wheel memories.
   logic [CNT_W-1:0]    count_mem [NUM_BUCKETS];
   logic [HANDLE_W-1:0] first_mem [NUM_BUCKETS];
   logic [HANDLE_W-1:0] last_mem  [NUM_BUCKETS];
   logic [HANDLE_W-1:0] link_mem  [HANDLE_SPACE];
   logic [CNT_W-1:0]    cnt_q;
   logic [HANDLE_W-1:0] first_q, last_q, link_q;

   logic                cnt_we, first_we, last_we, link_we;
   logic [BW-1:0]       cnt_waddr;
   logic [CNT_W-1:0]    cnt_wdata;
   logic [HANDLE_W-1:0] first_wdata, link_waddr, link_wdata;

   logic                div_start, div_done;
   logic [TIME_W-1:0]   div_dividend;
   logic [BW-1:0]       div_bucket;

   logic [TIME_W:0]     step_sum;
   logic                walk;
   logic [HANDLE_W-1:0] h;

   twp_divmod #(.NUM_BUCKETS(NUM_BUCKETS)) u_divmod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cfg.gran),
      .done     (div_done),
      .bucket   (div_bucket)
   );

   assign h        = item_ff.packet_handle;
   assign clearing = (state_ff == S_CLEAR);
   assign rsp_push = res_valid_ff;
   assign rsp_data = res_ff;

   // One head step: the bucket index of head + granularity is one more.
   assign step_sum = {1'b0, head_ff} + {{(TIME_W - GRAN_W + 1){1'b0}}, cfg.gran};
   assign walk     = (cnt_q == '0) && (head_ff < item_ff.now_time) && !step_sum[TIME_W]
                     && (steps_ff < SW'(NUM_BUCKETS));

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      head_in      = head_ff;
      max_in       = max_ff;
      t_in         = t_ff;
      elem_in      = elem_ff;
      b_in         = b_ff;
      clr_in       = clr_ff;
      steps_in     = steps_ff;
      res_valid_in = 1'b0;
      res_in       = res_ff;
      cmd_pop      = 1'b0;
      div_start    = 1'b0;
      div_dividend = head_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = b_ff;
      cnt_wdata    = cnt_q;
      first_we     = 1'b0;
      first_wdata  = h;
      last_we      = 1'b0;
      link_we      = 1'b0;
      link_waddr   = h;
      link_wdata   = '0;
      case (state_ff)
         // Sweep bucket counts to zero after reset.
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!cmd_empty && !rsp_full && !res_valid_ff) begin
               cmd_pop  = 1'b1;
               item_in  = cmd_data;
               state_in = (cmd_data.action == ACT_DEQUEUE) ? S_DEQ_START : S_ENQ_ANCHOR;
            end
         end
         // An enqueue into an empty wheel re-anchors it at now.
         S_ENQ_ANCHOR: begin
            if (elem_ff == '0) begin
               head_in = item_ff.now_time;
               max_in  = sat_add(item_ff.now_time, TIME_W'(cfg.horizon));
            end
            state_in = S_ENQ_CHECK;
         end
         S_ENQ_CHECK: begin
            if (EW'(elem_ff) >= EW'(cfg.limit)) begin
               res_valid_in         = 1'b1;
               res_in.status        = ST_DROPPED;
               res_in.out_handle    = '0;
               res_in.retry_time    = '0;
               res_in.occupancy     = OCC_W'(elem_ff);
               state_in             = S_IDLE;
            end else begin
               t_in     = (item_ff.send_time < head_ff) ? head_ff : item_ff.send_time;
               state_in = S_ENQ_CLAMP;
            end
         end
         S_ENQ_CLAMP: begin
            div_start    = 1'b1;
            div_dividend = (t_ff > max_ff) ? max_ff : t_ff;
            state_in     = S_ENQ_DIV;
         end
         S_ENQ_DIV: begin
            if (div_done) begin
               b_in     = div_bucket;
               state_in = S_ENQ_READ;
            end
         end
         S_ENQ_READ: begin
            state_in = S_ENQ_WRITE;
         end
         // Append the handle to the bucket list.
         S_ENQ_WRITE: begin
            link_we     = 1'b1;
            link_waddr  = h;
            link_wdata  = '0;
            first_we    = (cnt_q == '0);
            first_wdata = h;
            last_we     = 1'b1;
            cnt_we      = 1'b1;
            cnt_wdata   = cnt_q + 1'b1;
            elem_in     = elem_ff + 1'b1;
            t_in        = TIME_W'(last_q);
            if (cnt_q == '0) begin
               res_valid_in      = 1'b1;
               res_in.status     = ST_ACCEPTED;
               res_in.out_handle = '0;
               res_in.retry_time = '0;
               res_in.occupancy  = OCC_W'(elem_ff + 1'b1);
               state_in          = S_IDLE;
            end else begin
               state_in = S_ENQ_LINK;
            end
         end
         S_ENQ_LINK: begin
            link_we           = 1'b1;
            link_waddr        = t_ff[HANDLE_W-1:0];
            link_wdata        = h;
            res_valid_in      = 1'b1;
            res_in.status     = ST_ACCEPTED;
            res_in.out_handle = '0;
            res_in.retry_time = '0;
            res_in.occupancy  = OCC_W'(elem_ff);
            state_in          = S_IDLE;
         end
         S_DEQ_START: begin
            if (elem_ff == '0) begin
               head_in           = item_ff.now_time;
               max_in            = sat_add(item_ff.now_time, TIME_W'(cfg.horizon));
               res_valid_in      = 1'b1;
               res_in.status     = ST_EMPTY;
               res_in.out_handle = '0;
               res_in.retry_time = '0;
               res_in.occupancy  = '0;
               state_in          = S_IDLE;
            end else begin
               div_start    = 1'b1;
               div_dividend = head_ff;
               state_in     = S_DEQ_DIV;
            end
         end
         S_DEQ_DIV: begin
            if (div_done) begin
               b_in     = div_bucket;
               steps_in = '0;
               state_in = S_DEQ_READ;
            end
         end
         S_DEQ_READ: begin
            state_in = S_DEQ_CHECK;
         end
         // Walk the head over empty buckets up to now.
         S_DEQ_CHECK: begin
            if (walk) begin
               head_in  = step_sum[TIME_W-1:0];
               b_in     = (b_ff == BW'(NUM_BUCKETS - 1)) ? '0 : b_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = S_DEQ_READ;
            end else begin
               state_in = S_DEQ_HEAD;
            end
         end
         S_DEQ_HEAD: begin
            max_in       = sat_add(head_ff, TIME_W'(cfg.horizon));
            res_valid_in = 1'b1;
            if (cnt_q == '0) begin
               res_in.status     = ST_NOT_DUE;
               res_in.out_handle = '0;
               res_in.retry_time = sat_add(item_ff.now_time, TIME_W'(cfg.gran));
               res_in.occupancy  = OCC_W'(elem_ff);
            end else begin
               first_we          = 1'b1;
               first_wdata       = link_q;
               cnt_we            = 1'b1;
               cnt_wdata         = cnt_q - 1'b1;
               elem_in           = elem_ff - 1'b1;
               res_in.status     = ST_PACKET;
               res_in.out_handle = first_q;
               res_in.retry_time = '0;
               res_in.occupancy  = OCC_W'(elem_ff - 1'b1);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         max_ff       <= MAX_RST;
         elem_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         max_ff       <= max_in;
         elem_ff      <= elem_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      t_ff     <= t_in;
      b_ff     <= b_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
   end

   // Bucket count memory.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q <= count_mem[b_ff];
   end

   // Bucket head memory.
   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[b_ff] <= first_wdata;
      end
      first_q <= first_mem[b_ff];
   end

   // Bucket tail memory.
   always_ff @(posedge clock) begin
      if (last_we) begin
         last_mem[b_ff] <= h;
      end
      last_q <= last_mem[b_ff];
   end

   // Per-handle link memory, read at the current bucket head.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_q <= link_mem[first_q];
   end

endmodule

FILE: hw/rtl/timing_wheel_pacer.sv
`timescale 1ns / 1ps
// Top level of the timing-wheel pacer: front part, command queue, back part, result queue.
// Depends on twp_pkg, twp_front, twp_fifo and twp_engine.

// Requests are handled one at a time by the back part. How long an enqueue takes
// is set by the bit-serial bucket divider, which works out one quotient bit for
// each of the 64 dividend bits; a dequeue uses the same divider and also takes
// longer for every empty bucket the head walks over, through the registered read
// of the bucket count memory in the head walk. A two-entry queue on each side
// lets requests be taken and results wait while the back part works. After reset
// the block runs a clearing pass over its NUM_BUCKETS bucket counts, during which
// full stays high; configuration writes are taken at any time the block is idle.
module timing_wheel_pacer import twp_pkg::*; #(
   parameter int NUM_BUCKETS = 1024,
   parameter int CAPACITY    = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data
);

   logic    clearing;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   req_type cmd_wdata, cmd_rdata;
   logic    res_push, res_full;
   rsp_type res_wdata;
   cfg_type cfg;

   // Front part.
   twp_front #(.NUM_BUCKETS(NUM_BUCKETS), .CAPACITY(CAPACITY)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .clearing  (clearing),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wdata),
      .cmd_full  (cmd_full),
      .cfg       (cfg)
   );

   // Queue of requests between front and back.
   twp_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   // Back part.
   twp_engine #(.NUM_BUCKETS(NUM_BUCKETS), .CAPACITY(CAPACITY)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_wdata),
      .clearing  (clearing)
   );

   // Result queue toward the consumer.
   twp_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .full  (res_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty)
   );

endmodule

FILE: dv/timing_wheel_pacer_tb.sv
`timescale 1ns / 1ps
// Testbench of the timing-wheel pacer: a directed table, then random requests
// over several register settings, each checked against a behavioral schedule model.
// Depends on twp_pkg and timing_wheel_pacer.
module timing_wheel_pacer_tb;
   import twp_pkg::*;

   localparam int NBKT = 1024;
   localparam int CAP  = 4096;
   localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

   // One row of the directed table.
   typedef struct {
      logic          action;
      logic [63:0]   now_ns;
      logic [63:0]   send_ns;
      logic [11:0]   handle;
      bit            typed;
      rsp_type       known;
   } plan_row;

   // One phase of the random part.
   typedef struct {
      logic [GRAN_W-1:0]  gran;
      logic [HOR_W-1:0]   horizon;
      logic [LIMIT_W-1:0] limit;
      int                 count;
   } phase_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic push = 1'b0;
   logic full;
   req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_data;

   // Shadow of the wheel state.
   logic [63:0] sh_gran, sh_hor, sh_limit;
   logic [63:0] sh_head, sh_max;
   int unsigned sh_count;
   logic [11:0] sh_first [NBKT];
   logic [11:0] sh_last [NBKT];
   int unsigned sh_bcount [NBKT];
   logic [11:0] sh_link [CAP];
   bit          sh_held [CAP];

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      rsp_seen = 0;
   logic [63:0] cursor_ns = '0;
   int      burst_left = 0;

   timing_wheel_pacer uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? TMAX : s[63:0];
   endfunction

   function automatic logic [63:0] gran_eff();
      return (sh_gran == 0) ? 64'd1 : sh_gran;
   endfunction

   function automatic logic [63:0] reach_ns();
      logic [63:0] span;
      span = 64'(NBKT - 1) * gran_eff();
      return (sh_hor < span) ? sh_hor : span;
   endfunction

   function automatic int unsigned slot_of(input logic [63:0] t);
      return int'((t / gran_eff()) % NBKT);
   endfunction

   function automatic void re_anchor(input logic [63:0] now_ns);
      sh_head = now_ns;
      sh_max  = clip_add(now_ns, reach_ns());
   endfunction

   function automatic void wheel_reset();
      sh_gran  = 64'(GRAN_RESET);
      sh_hor   = 64'(HOR_RESET);
      sh_limit = 64'(LIMIT_RESET);
      sh_count = 0;
      foreach (sh_bcount[i]) sh_bcount[i] = 0;
      foreach (sh_held[i]) sh_held[i] = 1'b0;
      re_anchor(64'd0);
   endfunction

   // Computes the result of one request and advances the shadow wheel.
   function automatic rsp_type schedule_step(input req_type r);
      rsp_type     o;
      logic [63:0] t, h, g;
      int unsigned b, steps, lim;
      o = '0;
      lim = (sh_limit > CAP) ? CAP : int'(sh_limit);
      if (r.action == ACT_ENQUEUE) begin
         if (sh_count == 0) re_anchor(r.now_time);
         if (sh_count >= lim) begin
            o.status = ST_DROPPED;
         end else begin
            t = r.send_time;
            if (t < sh_head) t = sh_head;
            if (t > sh_max) t = sh_max;
            b = slot_of(t);
            sh_link[r.packet_handle] = '0;
            if (sh_bcount[b] == 0) sh_first[b] = r.packet_handle;
            else sh_link[sh_last[b]] = r.packet_handle;
            sh_last[b] = r.packet_handle;
            sh_bcount[b]++;
            sh_count++;
            sh_held[r.packet_handle] = 1'b1;
            o.status = ST_ACCEPTED;
         end
      end else if (sh_count == 0) begin
         re_anchor(r.now_time);
         o.status = ST_EMPTY;
      end else begin
         g = gran_eff();
         h = sh_head;
         b = slot_of(h);
         steps = 0;
         while (sh_bcount[b] == 0 && h < r.now_time && h <= TMAX - g && steps < NBKT) begin
            h = h + g;
            b = slot_of(h);
            steps++;
         end
         sh_head = h;
         sh_max = clip_add(h, reach_ns());
         if (sh_bcount[b] == 0) begin
            o.status = ST_NOT_DUE;
            o.retry_time = clip_add(r.now_time, g);
         end else begin
            o.out_handle = sh_first[b];
            sh_first[b] = sh_link[sh_first[b]];
            sh_bcount[b]--;
            sh_count--;
            sh_held[o.out_handle] = 1'b0;
            o.status = ST_PACKET;
         end
      end
      o.occupancy = OCC_W'(sh_count);
      return o;
   endfunction

   // Offers one request and waits until the block takes it.
   task automatic offer(input req_type r, input bit typed, input rsp_type known);
      rsp_type p;
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      p = schedule_step(r);
      pending_rsp.push_back(typed ? known : p);
      // Bursts of back-to-back requests separated by random gaps.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 15);
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Writes all three registers back to back while the block is idle.
   task automatic write_regs(input logic [GRAN_W-1:0] g, input logic [HOR_W-1:0] hz,
                             input logic [LIMIT_W-1:0] lim);
      csr_we <= 1'b1;
      csr_index <= CSR_GRANULARITY;
      csr_wdata <= CSR_DATA_W'(g);
      @(posedge clock);
      csr_index <= CSR_HORIZON;
      csr_wdata <= CSR_DATA_W'(hz);
      @(posedge clock);
      csr_index <= CSR_QUEUE_LIMIT;
      csr_wdata <= CSR_DATA_W'(lim);
      @(posedge clock);
      csr_we <= 1'b0;
      sh_gran = 64'(g);
      sh_hor = 64'(hz);
      sh_limit = 64'(lim);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic plan_row mk_row(input logic act, input logic [63:0] now_ns,
                                      input logic [63:0] send_ns, input logic [11:0] hd,
                                      input bit typed, input logic [2:0] st,
                                      input logic [11:0] oh, input logic [63:0] rt,
                                      input logic [12:0] occ);
      plan_row w;
      w.action = act;
      w.now_ns = now_ns;
      w.send_ns = send_ns;
      w.handle = hd;
      w.typed = typed;
      w.known.status = st;
      w.known.out_handle = oh;
      w.known.retry_time = rt;
      w.known.occupancy = occ;
      return w;
   endfunction

   // Builds a random request, mostly near the current time.
   function automatic req_type make_req();
      req_type     r;
      logic [63:0] g;
      int          k;
      g = gran_eff();
      r = '0;
      if ($urandom_range(0, 49) == 0) cursor_ns = {$urandom, $urandom};
      else cursor_ns = clip_add(cursor_ns, g * $urandom_range(0, 2) + $urandom_range(0, 3));
      r.now_time = cursor_ns;
      r.action = (sh_count < 8) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 1);
      if (r.action == ACT_ENQUEUE) begin
         k = $urandom_range(0, 9);
         if (k == 0) r.send_time = {$urandom, $urandom};
         else if (k == 1) r.send_time = cursor_ns - $urandom;
         else r.send_time = clip_add(cursor_ns, g * $urandom_range(0, 40)
                                     + $urandom_range(0, 999));
         r.packet_handle = 12'($urandom);
         for (k = 0; k < CAP && sh_held[r.packet_handle]; k++)
            r.packet_handle = r.packet_handle + 12'd1;
      end else begin
         r.send_time = {$urandom, $urandom};
         r.packet_handle = 12'($urandom);
      end
      return r;
   endfunction

   // Stimulus: directed table, then random phases.
   initial begin
      plan_row  plan [$];
      phase_row phases [$];
      req_type  r;
      rsp_type  none;
      none = '0;
      wheel_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(mk_row(ACT_DEQUEUE, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
      plan.push_back(mk_row(ACT_ENQUEUE, 0, 0, 0, 1, ST_ACCEPTED, 0, 0, 1));
      plan.push_back(mk_row(ACT_ENQUEUE, 5, TMAX, 12'hFFF, 1, ST_ACCEPTED, 0, 0, 2));
      plan.push_back(mk_row(ACT_DEQUEUE, 0, 0, 0, 1, ST_PACKET, 0, 0, 1));
      plan.push_back(mk_row(ACT_DEQUEUE, 1000, 0, 0, 1, ST_NOT_DUE, 0, 2000, 1));
      plan.push_back(mk_row(ACT_DEQUEUE, 2000000, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, 2000000, 0, 0, 1, ST_EMPTY, 0, 0, 0));
      // Send times behind the head and inside one bucket.
      plan.push_back(mk_row(ACT_ENQUEUE, 100, 50, 5, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_ENQUEUE, 100, 3000, 6, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_ENQUEUE, 100, 3000, 12'hAAA, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, 200, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, 5000, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, 5000, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, 5000, 0, 0, 0, 0, 0, 0, 0));
      // Time overflow near the top of the time range.
      plan.push_back(mk_row(ACT_ENQUEUE, TMAX - 99, TMAX, 7, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_ENQUEUE, TMAX - 99, 0, 12'h555, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, TMAX - 5000, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, TMAX, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, TMAX, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, TMAX, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_ENQUEUE, TMAX, TMAX, 9, 0, 0, 0, 0, 0));
      plan.push_back(mk_row(ACT_DEQUEUE, TMAX, 0, 0, 0, 0, 0, 0, 0));

      foreach (plan[i]) begin
         r.action = plan[i].action;
         r.now_time = plan[i].now_ns;
         r.send_time = plan[i].send_ns;
         r.packet_handle = plan[i].handle;
         offer(r, plan[i].typed, plan[i].known);
      end

      // Default settings first, then zero granularity with no room, the
      // widest values with an oversized limit, a tight wheel, and a fine one.
      phases.push_back('{GRAN_RESET, HOR_RESET, LIMIT_RESET, 200});
      phases.push_back('{32'd0, 40'd0, 13'd0, 60});
      phases.push_back('{32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 13'h1FFF, 120});
      phases.push_back('{32'd7, 40'd300, 13'd20, 150});
      phases.push_back('{32'd1, 40'd1023, 13'd4096, 100});
      foreach (phases[p]) begin
         wait_drained();
         write_regs(phases[p].gran, phases[p].horizon, phases[p].limit);
         cursor_ns = sh_head;
         repeat (phases[p].count) offer(make_req(), 1'b0, none);
      end

      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // Result side: random pops for the first 40 results, then one long hold-off to fill the block, then a stall pattern.
   initial begin
      int n;
      n = 0;
      @(negedge reset);
      while (rsp_seen < 40) begin
         pop <= ($urandom_range(0, 2) != 0);
         @(posedge clock);
      end
      pop <= 1'b0;
      repeat (3000) @(posedge clock);
      forever begin
         pop <= ((n % 500) < 150) ? 1'b1 : ($urandom_range(0, 9) < 6);
         n++;
         @(posedge clock);
      end
   end

   // Compares each taken result with the oldest pending one.
   always @(posedge clock) begin
      rsp_type w;
      int      bad;
      bad = 0;
      if (!reset && pop && !empty) begin
         rsp_seen <= rsp_seen + 1;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_data);
            bad++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_data.status !== w.status) begin
               $display("%0t: status expected %0d actual %0d", $time, w.status,
                        rsp_data.status);
               bad++;
            end
            if (rsp_data.out_handle !== w.out_handle) begin
               $display("%0t: out_handle expected %0d actual %0d", $time, w.out_handle,
                        rsp_data.out_handle);
               bad++;
            end
            if (rsp_data.retry_time !== w.retry_time) begin
               $display("%0t: retry_time expected %0h actual %0h", $time, w.retry_time,
                        rsp_data.retry_time);
               bad++;
            end
            if (rsp_data.occupancy !== w.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d", $time, w.occupancy,
                        rsp_data.occupancy);
               bad++;
            end
         end
         if (bad != 0) errors <= errors + bad;
      end
   end

   // Guard against a hung run.
   initial begin
      #60ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
